[design/pip_pkg.sv]
`default_nettype none

package pip_pkg;

    // Result kinds as seen on m_tuser.
    localparam logic [2:0] KIND_LISTEN_PORT = 3'd0;
    localparam logic [2:0] KIND_LISTED_IP   = 3'd1;
    localparam logic [2:0] KIND_LISTED_PORT = 3'd2;
    localparam logic [2:0] KIND_OBS_IP      = 3'd3;
    localparam logic [2:0] KIND_OBS_PORT    = 3'd4;
    localparam logic [2:0] KIND_ACCEPT      = 3'd5;
    localparam logic [2:0] KIND_REJECT      = 3'd6;

    // Reject causes.
    localparam logic [1:0] CAUSE_BAD_VERSION = 2'd0;
    localparam logic [1:0] CAUSE_TRUNCATED   = 2'd1;
    localparam logic [1:0] CAUSE_COUNT_LARGE = 2'd2;
    localparam logic [1:0] CAUSE_BAD_IP_LEN  = 2'd3;
    localparam logic [1:0] CAUSE_NONE        = 2'd0;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPECTED_VERSION  = 2'd0;
    localparam logic [1:0] CFG_MAX_ADDRESS_COUNT = 2'd1;
    localparam logic [1:0] CFG_MAX_IP_LENGTH     = 2'd2;

    localparam logic [7:0] RST_EXPECTED_VERSION  = 8'd1;
    localparam logic [7:0] RST_MAX_ADDRESS_COUNT = 8'd8;
    localparam logic [7:0] RST_MAX_IP_LENGTH     = 8'd64;

    // One parsed input word: a first result and an optional closing result,
    // which is always an accept or a reject.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic [7:0]  entry_idx;
        logic [7:0]  pos;
        logic [1:0]  cause;
        logic        has_second;
        logic        second_reject;
        logic [1:0]  second_cause;
    } pip_rec_t;

endpackage

`default_nettype wire

[design/pip_front.sv]
`default_nettype none

module pip_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_wdata,
    input  wire logic                 queue_full,
    output logic                      push,
    output pip_pkg::pip_rec_t         push_rec
);
    import pip_pkg::*;

    typedef enum logic [3:0] {
        PH_VERSION,
        PH_LPORT_HI,
        PH_LPORT_LO,
        PH_COUNT,
        PH_IPLEN,
        PH_IPBYTE,
        PH_APORT_HI,
        PH_APORT_LO,
        PH_OBSLEN,
        PH_OBSBYTE,
        PH_OPORT_HI,
        PH_OPORT_LO,
        PH_SETTLED
    } phase_t;

    logic [7:0] expected_version_reg;
    logic [7:0] max_address_count_reg;
    logic [7:0] max_ip_length_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] addresses_left_reg, addresses_left_next;
    logic [7:0] address_number_reg, address_number_next;
    logic [7:0] ip_bytes_left_reg, ip_bytes_left_next;
    logic [7:0] ip_byte_number_reg, ip_byte_number_next;
    logic [7:0] port_high_reg, port_high_next;

    logic        in_accept;
    logic        f_valid;
    logic [2:0]  f_kind;
    logic [15:0] f_value;
    logic [7:0]  f_idx;
    logic [7:0]  f_pos;
    logic        e_valid;
    logic        e_reject;
    logic [1:0]  e_cause;
    logic [15:0] port_word;

    assign s_tready  = !queue_full;
    assign in_accept = s_tvalid && s_tready;
    assign port_word = {port_high_reg, s_tdata};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_version_reg  <= RST_EXPECTED_VERSION;
            max_address_count_reg <= RST_MAX_ADDRESS_COUNT;
            max_ip_length_reg     <= RST_MAX_IP_LENGTH;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_EXPECTED_VERSION:  expected_version_reg  <= cfg_wdata;
                CFG_MAX_ADDRESS_COUNT: max_address_count_reg <= cfg_wdata;
                CFG_MAX_IP_LENGTH:     max_ip_length_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next          = phase_reg;
        addresses_left_next = addresses_left_reg;
        address_number_next = address_number_reg;
        ip_bytes_left_next  = ip_bytes_left_reg;
        ip_byte_number_next = ip_byte_number_reg;
        port_high_next      = port_high_reg;
        f_valid  = 1'b0;
        f_kind   = KIND_LISTEN_PORT;
        f_value  = 16'd0;
        f_idx    = 8'd0;
        f_pos    = 8'd0;
        e_valid  = 1'b0;
        e_reject = 1'b1;
        e_cause  = CAUSE_NONE;

        unique case (phase_reg)
            PH_VERSION: begin
                if (s_tdata != expected_version_reg) begin
                    e_valid    = 1'b1;
                    e_cause    = CAUSE_BAD_VERSION;
                    phase_next = PH_SETTLED;
                end else begin
                    phase_next = PH_LPORT_HI;
                end
            end
            PH_LPORT_HI: begin
                port_high_next = s_tdata;
                phase_next     = PH_LPORT_LO;
            end
            PH_LPORT_LO: begin
                f_valid    = 1'b1;
                f_kind     = KIND_LISTEN_PORT;
                f_value    = port_word;
                phase_next = PH_COUNT;
            end
            PH_COUNT: begin
                if (s_tdata > max_address_count_reg) begin
                    e_valid    = 1'b1;
                    e_cause    = CAUSE_COUNT_LARGE;
                    phase_next = PH_SETTLED;
                end else begin
                    addresses_left_next = s_tdata;
                    address_number_next = 8'd0;
                    phase_next = (s_tdata == 8'd0) ? PH_OBSLEN : PH_IPLEN;
                end
            end
            PH_IPLEN: begin
                if (s_tdata == 8'd0 || s_tdata > max_ip_length_reg) begin
                    e_valid    = 1'b1;
                    e_cause    = CAUSE_BAD_IP_LEN;
                    phase_next = PH_SETTLED;
                end else begin
                    ip_bytes_left_next  = s_tdata;
                    ip_byte_number_next = 8'd0;
                    phase_next          = PH_IPBYTE;
                end
            end
            PH_IPBYTE: begin
                f_valid = 1'b1;
                f_kind  = KIND_LISTED_IP;
                f_value = {8'd0, s_tdata};
                f_idx   = address_number_reg;
                f_pos   = ip_byte_number_reg;
                ip_byte_number_next = ip_byte_number_reg + 8'd1;
                ip_bytes_left_next  = ip_bytes_left_reg - 8'd1;
                if (ip_bytes_left_reg == 8'd1) begin
                    phase_next = PH_APORT_HI;
                end
            end
            PH_APORT_HI: begin
                port_high_next = s_tdata;
                phase_next     = PH_APORT_LO;
            end
            PH_APORT_LO: begin
                f_valid = 1'b1;
                f_kind  = KIND_LISTED_PORT;
                f_value = port_word;
                f_idx   = address_number_reg;
                address_number_next = address_number_reg + 8'd1;
                addresses_left_next = addresses_left_reg - 8'd1;
                phase_next = (addresses_left_reg == 8'd1) ? PH_OBSLEN : PH_IPLEN;
            end
            PH_OBSLEN: begin
                if (s_tdata == 8'd0) begin
                    e_valid    = 1'b1;
                    e_reject   = 1'b0;
                    phase_next = PH_SETTLED;
                end else if (s_tdata > max_ip_length_reg) begin
                    e_valid    = 1'b1;
                    e_cause    = CAUSE_BAD_IP_LEN;
                    phase_next = PH_SETTLED;
                end else begin
                    ip_bytes_left_next  = s_tdata;
                    ip_byte_number_next = 8'd0;
                    phase_next          = PH_OBSBYTE;
                end
            end
            PH_OBSBYTE: begin
                f_valid = 1'b1;
                f_kind  = KIND_OBS_IP;
                f_value = {8'd0, s_tdata};
                f_pos   = ip_byte_number_reg;
                ip_byte_number_next = ip_byte_number_reg + 8'd1;
                ip_bytes_left_next  = ip_bytes_left_reg - 8'd1;
                if (ip_bytes_left_reg == 8'd1) begin
                    phase_next = PH_OPORT_HI;
                end
            end
            PH_OPORT_HI: begin
                port_high_next = s_tdata;
                phase_next     = PH_OPORT_LO;
            end
            PH_OPORT_LO: begin
                f_valid    = 1'b1;
                f_kind     = KIND_OBS_PORT;
                f_value    = port_word;
                e_valid    = 1'b1;
                e_reject   = 1'b0;
                phase_next = PH_SETTLED;
            end
            // A settled message ignores bytes; stray codes settle too.
            default: begin
                phase_next = PH_SETTLED;
            end
        endcase

        if (s_tlast) begin
            // The final byte of the buffer closes any message still open.
            if (phase_next != PH_SETTLED) begin
                e_valid  = 1'b1;
                e_reject = 1'b1;
                e_cause  = CAUSE_TRUNCATED;
            end
            phase_next          = PH_VERSION;
            addresses_left_next = 8'd0;
            address_number_next = 8'd0;
            ip_bytes_left_next  = 8'd0;
            ip_byte_number_next = 8'd0;
            port_high_next      = 8'd0;
        end
    end

    always_comb begin
        push = in_accept && (f_valid || e_valid);
        if (f_valid) begin
            push_rec.kind          = f_kind;
            push_rec.value         = f_value;
            push_rec.entry_idx     = f_idx;
            push_rec.pos           = f_pos;
            push_rec.cause         = CAUSE_NONE;
            push_rec.has_second    = e_valid;
            push_rec.second_reject = e_reject;
            push_rec.second_cause  = e_reject ? e_cause : CAUSE_NONE;
        end else begin
            push_rec.kind          = e_reject ? KIND_REJECT : KIND_ACCEPT;
            push_rec.value         = 16'd0;
            push_rec.entry_idx     = 8'd0;
            push_rec.pos           = 8'd0;
            push_rec.cause         = e_reject ? e_cause : CAUSE_NONE;
            push_rec.has_second    = 1'b0;
            push_rec.second_reject = 1'b0;
            push_rec.second_cause  = CAUSE_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_VERSION;
            addresses_left_reg <= 8'd0;
            address_number_reg <= 8'd0;
            ip_bytes_left_reg  <= 8'd0;
            ip_byte_number_reg <= 8'd0;
            port_high_reg      <= 8'd0;
        end else if (in_accept) begin
            phase_reg          <= phase_next;
            addresses_left_reg <= addresses_left_next;
            address_number_reg <= address_number_next;
            ip_bytes_left_reg  <= ip_bytes_left_next;
            ip_byte_number_reg <= ip_byte_number_next;
            port_high_reg      <= port_high_next;
        end
    end

`ifndef SYNTH
    // Bytes after a settled message never produce results.
    a_settled_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && phase_reg == PH_SETTLED) |-> !push)
        else $error("settled message produced a result");
`endif

endmodule

`default_nettype wire

[design/pip_queue.sv]
`default_nettype none

module pip_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire pip_pkg::pip_rec_t push_rec,
    input  wire logic              pop,
    output pip_pkg::pip_rec_t      head,
    output logic                   full,
    output logic                   empty
);
    import pip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    pip_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("word queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("word queue read while empty");
`endif

endmodule

`default_nettype wire

[design/pip_back.sv]
`default_nettype none

module pip_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pip_pkg::pip_rec_t head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [2:0]             m_kind,
    output logic [15:0]            m_value,
    output logic [7:0]             m_entry_idx,
    output logic [7:0]             m_pos,
    output logic [1:0]             m_cause,
    output logic                   m_tlast
);
    import pip_pkg::*;

    logic        m_tvalid_reg;
    logic        second_reg;
    logic        load;
    logic [2:0]  kind_reg;
    logic [15:0] value_reg;
    logic [7:0]  entry_idx_reg;
    logic [7:0]  pos_reg;
    logic [1:0]  cause_reg;
    logic        last_reg;

    // The output register refills whenever it is empty or being taken.
    assign load = !m_tvalid_reg || m_tready;
    assign pop  = load && !empty && (second_reg || !head.has_second);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            second_reg   <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= !empty;
            if (!empty) begin
                second_reg <= !second_reg && head.has_second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) begin
            if (second_reg) begin
                kind_reg      <= head.second_reject ? KIND_REJECT : KIND_ACCEPT;
                value_reg     <= 16'd0;
                entry_idx_reg <= 8'd0;
                pos_reg       <= 8'd0;
                cause_reg     <= head.second_cause;
                last_reg      <= 1'b1;
            end else begin
                kind_reg      <= head.kind;
                value_reg     <= head.value;
                entry_idx_reg <= head.entry_idx;
                pos_reg       <= head.pos;
                cause_reg     <= head.cause;
                last_reg      <= !head.has_second;
            end
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign m_kind      = kind_reg;
    assign m_value     = value_reg;
    assign m_entry_idx = entry_idx_reg;
    assign m_pos       = pos_reg;
    assign m_cause     = cause_reg;
    assign m_tlast     = last_reg;

`ifndef SYNTH
    // While the closing result of a word is pending, that word stays queued.
    a_second_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> !empty)
        else $error("closing result pending with no queued word");
`endif

endmodule

`default_nettype wire

[design/peer_identify_parser.sv]
`default_nettype none

// Peer identify message parser.
// The s_ channel carries the message one byte per word; s_tlast marks the
// last byte of the buffer. The m_ channel carries the parsed fields as they
// complete, then one accept or reject word; m_tuser gives the kind and
// m_tlast marks the last result caused by one input byte.
// The configuration port writes expected_version (index 0), max_address_count
// (index 1) and max_ip_length (index 2) on any edge with cfg_wr_en high.
// Throughput: one input byte per cycle while the queue is not full. A byte
// causes at most two results and the output drains one result per cycle
// while m_tready is high, so only the observed port (field plus accept) and
// a truncated field cause two results; the word queue of QUEUE_DEPTH
// entries absorbs these. The parser writes each result word into the queue
// when its byte is accepted, and the output register loads it from the
// queue head once that register is empty or being taken.
// When the receiver stalls, the output word holds, the queue fills and then
// s_tready drops. A synchronous reset empties the queue, drops m_tvalid,
// returns the parser to the version byte and restores the register defaults.
module peer_identify_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] field_value, [23:16] entry_index, [31:24] byte_position,
    // [33:32] reject_cause, [39:34] zero
    output logic [39:0]      m_tdata,
    output logic [2:0]       m_tuser,   // [2:0] item_kind
    output logic             m_tlast,   // run_end
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    import pip_pkg::*;

    pip_rec_t    push_rec;
    pip_rec_t    head;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    logic [15:0] value;
    logic [7:0]  entry_idx;
    logic [7:0]  pos;
    logic [1:0]  cause;

    pip_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .queue_full (full),
        .push       (push),
        .push_rec   (push_rec)
    );

    pip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    pip_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_kind      (m_tuser),
        .m_value     (value),
        .m_entry_idx (entry_idx),
        .m_pos       (pos),
        .m_cause     (cause),
        .m_tlast     (m_tlast)
    );

    assign m_tdata = {6'd0, cause, pos, entry_idx, value};

endmodule

`default_nettype wire
